[hdl/ogrc_pkg.sv]
// ----------------------------------------------------------------------------
// ogrc_pkg
// Shared types, constants and tables for the occupancy grid ray cast core.
// ----------------------------------------------------------------------------
package ogrc_pkg;

    // Map and march sizes
    localparam int MAP_CELLS = 65536;
    localparam int MAX_STEPS = 1024;

    localparam int AW  = $clog2(MAP_CELLS);      // cell address width
    localparam int QW  = AW + 1;                 // cell coordinate quotient width
    localparam int QCW = $clog2(QW + 1);         // divider iteration counter width
    localparam int NW  = $clog2(MAX_STEPS) + 1;  // step counter width
    localparam int PW  = 40;                     // signed point / offset width
    localparam int DW  = 31 + QW + 1;            // divider working width
    localparam int LW  = QW + 10;                // linear index width
    localparam int MW  = 33;                     // shared multiplier operand width
    localparam int CW  = 34;                     // CORDIC datapath width

    // Stream packing offsets (input tdata)
    localparam int TD_CELL_INDEX = 0;
    localparam int TD_CELL_VALUE = 16;
    localparam int TD_START_X    = 18;
    localparam int TD_START_Y    = 50;
    localparam int TD_HEADING    = 82;
    localparam int TD_RANGE      = 98;
    localparam int S_TDATA_W     = 136;

    localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

    // Register reset values
    localparam logic [30:0] CELL_SIZE_RST  = 31'd3277;
    localparam logic [8:0]  GRID_WIDTH_RST = 9'd256;
    localparam logic [30:0] MAX_SEARCH_RST = 31'd1310720;
    localparam logic [15:0] NOISE_RST      = 16'd6554;

    // Cell classes
    localparam logic [1:0] CELL_OCCUPIED = 2'd1;
    localparam logic [1:0] CELL_UNKNOWN  = 2'd2;

    // Item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_CAST  = 1'b1;

    typedef enum logic [1:0] {
        OUT_HIT     = 2'd0,
        OUT_UNKNOWN = 2'd1,
        OUT_LIMIT   = 2'd2,
        OUT_OUTSIDE = 2'd3
    } outcome_t;

    typedef enum logic [2:0] {
        REG_ORIGIN_X   = 3'd0,
        REG_ORIGIN_Y   = 3'd1,
        REG_CELL_SIZE  = 3'd2,
        REG_GRID_WIDTH = 3'd3,
        REG_MAX_SEARCH = 3'd4,
        REG_NOISE      = 3'd5
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CORDIC,
        ST_LIMIT,
        ST_LIMIT_W,
        ST_CHECK,
        ST_MUL_X,
        ST_MUL_Y,
        ST_DIFF,
        ST_DIV_X,
        ST_DIV_Y,
        ST_LIN,
        ST_READ,
        ST_EVAL,
        ST_DONE
    } state_t;

    // Arctangent of 2^-i, in turns as Q0.32
    function automatic logic [29:0] atan_val(input logic [3:0] i);
        logic [29:0] r;
        begin
            case (i)
                4'd0:    r = 30'd536870912;
                4'd1:    r = 30'd316933406;
                4'd2:    r = 30'd167458907;
                4'd3:    r = 30'd85004756;
                4'd4:    r = 30'd42667331;
                4'd5:    r = 30'd21354465;
                4'd6:    r = 30'd10679838;
                4'd7:    r = 30'd5340245;
                4'd8:    r = 30'd2670163;
                4'd9:    r = 30'd1335087;
                4'd10:   r = 30'd667544;
                4'd11:   r = 30'd333772;
                4'd12:   r = 30'd166886;
                4'd13:   r = 30'd83443;
                4'd14:   r = 30'd41722;
                default: r = 30'd20861;
            endcase
            return r;
        end
    endfunction

endpackage

[hdl/occupancy_grid_ray_cast_core.sv]
// ----------------------------------------------------------------------------
// occupancy_grid_ray_cast_core
// Occupancy grid held in RAM, with a ray marcher that returns the distance of
// the first occupied cell or the range limit, or flags an unknown or off-map cell.
// ----------------------------------------------------------------------------
//  channel   signals                        transfer carries
//  s_axis    tvalid tready tdata tuser      map write (tuser 0) or ray cast
//  m_axis    tvalid tready tdata tuser      distance and outcome per cast
//  cfg       valid ready index data         register writes, always ready
//
// A map write is done in the cycle it is accepted. A cast runs the CORDIC and
// the range limit, then per march step two multiplies, an X and a Y divide, a
// map read and an evaluation, and then hands the result over.
// After reset a clearing pass writes every cell (MAP_CELLS, 65536) unknown,
// with s_axis_tready low. A stalled m_axis holds one finished result
// while the next item is taken; a further result waits in the done state.
// ----------------------------------------------------------------------------
module occupancy_grid_ray_cast_core import ogrc_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    // cell_index, cell_value, start_x, start_y, heading, measured_range
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // kind
    input  logic                 s_axis_tuser,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // distance
    output logic [31:0]          m_axis_tdata,
    // outcome
    output logic [1:0]           m_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    // Configuration registers
    logic signed [31:0] origin_x_reg, origin_y_reg;
    logic [30:0]        cell_size_reg, max_search_reg;
    logic [8:0]         grid_width_reg;
    logic [15:0]        noise_reg;

    // Sequencer state
    state_t               state_reg, state_next;
    logic [AW-1:0]        clr_reg, clr_next;
    logic signed [31:0]   sx_reg, sy_reg;
    logic [30:0]          range_reg, limit_reg, limit_next;
    logic [31:0]          d_reg, d_next;
    logic [NW-1:0]        n_reg, n_next;
    logic signed [PW-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [QW-1:0]        ix_reg, ix_next;
    logic [LW-1:0]        lin_reg, lin_next;
    logic [31:0]          res_dist_reg, res_dist_next;
    outcome_t             res_out_reg, res_out_next;
    logic                 out_valid_reg, out_valid_next;
    logic [31:0]          out_data_reg, out_data_next;
    outcome_t             out_user_reg, out_user_next;

    // Unit connections
    logic                   accept, cordic_start, cordic_done;
    logic signed [MW-1:0]   cos_v, sin_v, mul_a, mul_b;
    logic signed [2*MW-1:0] product, prod_sh;
    logic                   div_start, div_done, div_ovf;
    logic [PW-1:0]          div_dividend;
    logic [QW-1:0]          quot;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [1:0]             ram_wdata, cell_v;
    logic [AW+15:0]         wr_idx;

    // Datapath helpers
    logic [30:0]          step;
    logic [31:0]          far;
    logic [18:0]          factor;
    logic [33:0]          lim_raw;
    logic signed [PW-1:0] pt_off, dy_calc;
    logic [QW+8:0]        iy_gw;

    ogrc_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .heading (s_axis_tdata[TD_HEADING +: 16]),
        .done    (cordic_done),
        .cos_out (cos_v),
        .sin_out (sin_v)
    );

    ogrc_mul u_mul (
        .clk     (clk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (product)
    );

    ogrc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (step),
        .done     (div_done),
        .quotient (quot),
        .overflow (div_ovf)
    );

    ogrc_ram #(.WIDTH(2), .DEPTH(MAP_CELLS)) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (lin_reg[AW-1:0]),
        .rd_data (cell_v)
    );

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            cell_size_reg  <= CELL_SIZE_RST;
            grid_width_reg <= GRID_WIDTH_RST;
            max_search_reg <= MAX_SEARCH_RST;
            noise_reg      <= NOISE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ORIGIN_X:   origin_x_reg   <= cfg_data;
                REG_ORIGIN_Y:   origin_y_reg   <= cfg_data;
                REG_CELL_SIZE:  cell_size_reg  <= cfg_data[30:0];
                REG_GRID_WIDTH: grid_width_reg <= cfg_data[8:0];
                REG_MAX_SEARCH: max_search_reg <= cfg_data[30:0];
                REG_NOISE:      noise_reg      <= cfg_data[15:0];
                default:        ;
            endcase
        end
    end

    // Shared arithmetic
    always_comb
    begin
        step    = (cell_size_reg == '0) ? 31'd1 : cell_size_reg;
        far     = {max_search_reg, 1'b0};
        factor  = 19'd65536 + ({3'b000, noise_reg} + {1'b0, noise_reg, 2'b00});
        lim_raw = product[49:16];
        prod_sh = product >>> 30;
        pt_off  = prod_sh[PW-1:0];
        dy_calc = {{(PW-32){sy_reg[31]}}, sy_reg} + pt_off
                - {{(PW-32){origin_y_reg[31]}}, origin_y_reg};
        iy_gw   = {9'b0, quot} * {{QW{1'b0}}, grid_width_reg};
        wr_idx  = {{AW{1'b0}}, s_axis_tdata[TD_CELL_INDEX +: 16]};
        if (state_reg == ST_LIMIT)
        begin
            mul_a = {2'b00, range_reg};
            mul_b = {14'b0, factor};
        end
        else
        begin
            mul_a = {1'b0, d_reg};
            mul_b = (state_reg == ST_MUL_Y) ? sin_v : cos_v;
        end
    end

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cordic_start  = accept && (s_axis_tuser == KIND_CAST);

    // Map write port: clearing pass or cell load
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = CELL_UNKNOWN;
        end
        else
        begin
            ram_we    = accept && (s_axis_tuser == KIND_WRITE)
                        && (wr_idx < (AW+16)'(MAP_CELLS));
            ram_waddr = wr_idx[AW-1:0];
            ram_wdata = s_axis_tdata[TD_CELL_VALUE +: 2];
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        limit_next     = limit_reg;
        d_next         = d_reg;
        n_next         = n_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        ix_next        = ix_reg;
        lin_next       = lin_reg;
        res_dist_next  = res_dist_reg;
        res_out_next   = res_out_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        div_start      = 1'b0;
        div_dividend   = dx_reg;

        // Drop the held result once taken
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(MAP_CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cordic_start)
                begin
                    state_next = ST_CORDIC;
                end
            end
            ST_CORDIC:
            begin
                if (cordic_done)
                begin
                    state_next = ST_LIMIT;
                end
            end
            ST_LIMIT:
            begin
                state_next = ST_LIMIT_W;
            end
            ST_LIMIT_W:
            begin
                limit_next = (lim_raw > {3'b000, max_search_reg}) ? max_search_reg
                                                                   : lim_raw[30:0];
                d_next     = {1'b0, step};
                n_next     = '0;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if ((n_reg < NW'(MAX_STEPS)) && (d_reg <= {1'b0, limit_reg}))
                begin
                    state_next = ST_MUL_X;
                end
                else
                begin
                    res_dist_next = {1'b0, limit_reg};
                    res_out_next  = OUT_LIMIT;
                    state_next    = ST_DONE;
                end
            end
            ST_MUL_X:
            begin
                state_next = ST_MUL_Y;
            end
            ST_MUL_Y:
            begin
                dx_next = {{(PW-32){sx_reg[31]}}, sx_reg} + pt_off
                        - {{(PW-32){origin_x_reg[31]}}, origin_x_reg};
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                dy_next = dy_calc;
                if (dx_reg[PW-1] || dy_calc[PW-1])
                begin
                    res_dist_next = far;
                    res_out_next  = OUT_OUTSIDE;
                    state_next    = ST_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_X;
                end
            end
            ST_DIV_X:
            begin
                if (div_done)
                begin
                    ix_next = quot;
                    if (div_ovf || ({9'b0, quot} >= {{QW{1'b0}}, grid_width_reg}))
                    begin
                        res_dist_next = far;
                        res_out_next  = OUT_OUTSIDE;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        div_start    = 1'b1;
                        div_dividend = dy_reg;
                        state_next   = ST_DIV_Y;
                    end
                end
            end
            ST_DIV_Y:
            begin
                if (div_done)
                begin
                    if (div_ovf)
                    begin
                        res_dist_next = far;
                        res_out_next  = OUT_OUTSIDE;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        lin_next   = {1'b0, iy_gw} + {{(LW-QW){1'b0}}, ix_reg};
                        state_next = ST_LIN;
                    end
                end
            end
            ST_LIN:
            begin
                if (lin_reg >= LW'(MAP_CELLS))
                begin
                    res_dist_next = far;
                    res_out_next  = OUT_OUTSIDE;
                    state_next    = ST_DONE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (cell_v == CELL_OCCUPIED)
                begin
                    res_dist_next = d_reg;
                    res_out_next  = OUT_HIT;
                    state_next    = ST_DONE;
                end
                else if (cell_v >= CELL_UNKNOWN)
                begin
                    res_dist_next = far;
                    res_out_next  = OUT_UNKNOWN;
                    state_next    = ST_DONE;
                end
                else
                begin
                    d_next     = d_reg + {1'b0, step};
                    n_next     = n_reg + NW'(1);
                    state_next = ST_CHECK;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_dist_reg;
                    out_user_next  = res_out_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            n_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            n_reg         <= n_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cordic_start)
        begin
            sx_reg    <= s_axis_tdata[TD_START_X +: 32];
            sy_reg    <= s_axis_tdata[TD_START_Y +: 32];
            range_reg <= s_axis_tdata[TD_RANGE +: 31];
        end
        limit_reg    <= limit_next;
        d_reg        <= d_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        ix_reg       <= ix_next;
        lin_reg      <= lin_next;
        res_dist_reg <= res_dist_next;
        res_out_reg  <= res_out_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

[hdl/ogrc_ram.sv]
// ----------------------------------------------------------------------------
// ogrc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ogrc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/ogrc_mul.sv]
// ----------------------------------------------------------------------------
// ogrc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module ogrc_mul import ogrc_pkg::*; (
    input  logic                   clk,
    input  logic signed [MW-1:0]   op_a,
    input  logic signed [MW-1:0]   op_b,
    output logic signed [2*MW-1:0] product
);

    logic signed [2*MW-1:0] product_reg;

    // Register the product every cycle
    always_ff @(posedge clk)
    begin
        product_reg <= op_a * op_b;
    end

    assign product = product_reg;

endmodule

[hdl/ogrc_cordic.sv]
// ----------------------------------------------------------------------------
// ogrc_cordic
// Iterative 16-step rotation CORDIC giving cosine and sine in Q2.30.
// ----------------------------------------------------------------------------
module ogrc_cordic import ogrc_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [15:0]          heading,
    output logic                 done,
    output logic signed [MW-1:0] cos_out,
    output logic signed [MW-1:0] sin_out
);

    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic [3:0]           i_reg;
    logic                 run_reg, flip_reg, done_reg;

    logic [31:0]          angle, angle_f;
    logic                 fold;
    logic signed [CW-1:0] dx, dy, at, neg_x, neg_y;

    // Fold the second and third quadrants onto the right half plane
    always_comb
    begin
        angle   = {heading, 16'h0000};
        fold    = (angle[31:30] == 2'd1) || (angle[31:30] == 2'd2);
        angle_f = fold ? (angle ^ 32'h8000_0000) : angle;
        dx      = y_reg >>> i_reg;
        dy      = x_reg >>> i_reg;
        at      = {{(CW-30){1'b0}}, atan_val(i_reg)};
        neg_x   = -x_reg;
        neg_y   = -y_reg;
    end

    // Iterate one micro-rotation per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= 4'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                i_reg   <= 4'd0;
            end
            else if (run_reg)
            begin
                i_reg <= i_reg + 4'd1;
                if (i_reg == 4'd15)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= {{(CW-32){1'b0}}, CORDIC_GAIN};
            y_reg    <= '0;
            z_reg    <= {{(CW-32){angle_f[31]}}, angle_f};
            flip_reg <= fold;
        end
        else if (run_reg)
        begin
            if (!z_reg[CW-1])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
        end
    end

    assign done    = done_reg;
    assign cos_out = flip_reg ? neg_x[MW-1:0] : x_reg[MW-1:0];
    assign sin_out = flip_reg ? neg_y[MW-1:0] : y_reg[MW-1:0];

endmodule

[hdl/ogrc_div.sv]
// ----------------------------------------------------------------------------
// ogrc_div
// Restoring divider, one quotient bit per cycle, with quotient overflow flag.
// ----------------------------------------------------------------------------
module ogrc_div import ogrc_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [PW-1:0] dividend,
    input  logic [30:0]   divisor,
    output logic          done,
    output logic [QW-1:0] quotient,
    output logic          overflow
);

    logic [DW-1:0]  rem_reg, dsh_reg;
    logic [QW-1:0]  q_reg;
    logic [QCW-1:0] cnt_reg;
    logic           run_reg, done_reg, ovf_reg;

    logic [DW-1:0]  dividend_x, divisor_x, rem_sub;
    logic           fits;

    always_comb
    begin
        dividend_x = {{(DW-PW){1'b0}}, dividend};
        divisor_x  = {{(DW-31){1'b0}}, divisor};
        fits       = rem_reg >= dsh_reg;
        rem_sub    = rem_reg - dsh_reg;
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= QCW'(QW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - QCW'(1);
                if (cnt_reg == QCW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Subtract and shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend_x;
            dsh_reg <= divisor_x << (QW - 1);
            q_reg   <= '0;
            ovf_reg <= dividend_x >= (divisor_x << QW);
        end
        else if (run_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_sub;
            end
            q_reg   <= {q_reg[QW-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;
    assign overflow = ovf_reg;

endmodule

[hdl/ogrc_checker.sv]
// ----------------------------------------------------------------------------
// ogrc_checker
// Port-level checks for the ray cast core, bound to the top level.
// ----------------------------------------------------------------------------
module ogrc_checker import ogrc_pkg::*; (
    input logic                 clk,
    input logic                 rst_n,
    input logic [S_TDATA_W-1:0] s_axis_tdata,
    input logic                 s_axis_tuser,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [31:0]          m_axis_tdata,
    input logic [1:0]           m_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [2:0]           cfg_index,
    input logic [31:0]          cfg_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // A cast keeps the input closed while it marches
    a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_CAST |=> !s_axis_tready)
        else $error("input open during cast");

    // A map write leaves the input open
    a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_WRITE |=> s_axis_tready)
        else $error("map write stalled input");

    // A hit lies at least one step out
    a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == OUT_HIT |-> m_axis_tdata != 32'd0)
        else $error("hit at zero distance");

    // Unknown and outside report twice the search range, always even
    a_far_even: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == OUT_UNKNOWN || m_axis_tuser == OUT_OUTSIDE)
        |-> !m_axis_tdata[0])
        else $error("odd far distance");

endmodule

bind occupancy_grid_ray_cast_core ogrc_checker u_ogrc_checker (.*);
